@@ hw/rtl/lgpe_pkg.sv @@
package lgpe_pkg;

    // Default grid size
    localparam int LGPE_MAX_COLS = 64;
    localparam int LGPE_MAX_ROWS = 64;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int CMD_W      = 8;
    localparam int ROW_IDX_W  = 6;
    localparam int ROW_BITS_W = 64;
    localparam int DIM_W      = 7;
    localparam int GEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Request types
    localparam logic [REQ_W-1:0] REQ_CMD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Result kinds
    localparam logic RES_DONE = 1'b0;
    localparam logic RES_ROW  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENS   = 2'd2;

    // Configuration reset values
    localparam logic [DIM_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [GEN_W-1:0] GENS_RST   = 16'd0;

    // Drawing command characters
    localparam logic [CMD_W-1:0] CH_UP    = 8'h77; // 'w'
    localparam logic [CMD_W-1:0] CH_DOWN  = 8'h73; // 's'
    localparam logic [CMD_W-1:0] CH_LEFT  = 8'h61; // 'a'
    localparam logic [CMD_W-1:0] CH_RIGHT = 8'h64; // 'd'
    localparam logic [CMD_W-1:0] CH_PEN   = 8'h78; // 'x'

    // Controller to datapath commands
    typedef struct packed {
        logic cmd_apply;
        logic run_start;
        logic life_start;
        logic rd_start;
        logic load_row;
        logic load_done;
    } lgpe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic             pass_done;
        logic [GEN_W-1:0] gen_count;
    } lgpe_stat_t;

endpackage

@@ hw/rtl/life_grid_pen_and_evolve_top.sv @@
// Game of Life grid (B3/S23, dead border) with a cursor pen. Command bytes
// are accepted back to back while no result waits; a waiting result holds
// the input until it is taken. A row read is registered out of the row
// memory and then into the result register. A run makes a column-mask pass
// and then one pass per generation, each streaming the rows in use through
// the single read port of the row memory at one row per cycle.
// Per-row valid bits make the grid read as all dead right after reset, with
// no clearing pass. Configuration is accepted at any time with cfg_ready
// always high, but must only be written while the block is idle.
module life_grid_pen_and_evolve_top
    import lgpe_pkg::*;
#(
    parameter int MAX_COLS = LGPE_MAX_COLS,
    parameter int MAX_ROWS = LGPE_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [CMD_W-1:0]      cmd_byte,
    input  logic [ROW_IDX_W-1:0]  row_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  result_kind,
    output logic [ROW_BITS_W-1:0] row_bits
);

    lgpe_cmd_t  cmd;
    lgpe_stat_t st;

    assign cfg_ready = 1'b1;

    lgpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    lgpe_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_byte    (cmd_byte),
        .row_index   (row_index),
        .cmd         (cmd),
        .st          (st),
        .result_kind (result_kind),
        .row_bits    (row_bits)
    );

endmodule

@@ hw/rtl/lgpe_ctrl.sv @@
module lgpe_ctrl
    import lgpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req_type,
    output logic             out_valid,
    input  logic             out_ready,
    output lgpe_cmd_t        cmd,
    input  lgpe_stat_t       st
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_PASS
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [GEN_W-1:0] gen_left_reg;
    logic [GEN_W-1:0] gen_left_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        gen_left_next  = gen_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    unique case (req_type)
                        REQ_CMD:
                        begin
                            cmd.cmd_apply = 1'b1;
                        end
                        REQ_RUN:
                        begin
                            cmd.run_start = 1'b1;
                            gen_left_next = st.gen_count;
                            state_next    = ST_PASS;
                        end
                        REQ_READ:
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = ST_RD_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.load_row   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_PASS:
            begin
                if (st.pass_done)
                begin
                    if (gen_left_reg == '0)
                    begin
                        cmd.load_done  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // chain the next generation straight on
                        gen_left_next  = gen_left_reg - GEN_W'(1);
                        cmd.life_start = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_left_reg  <= gen_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        st.pass_done |-> (state_reg == ST_PASS))
        else $error("pass finished outside a run");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_RD_WAIT) || ($past(state_reg) == ST_PASS))
        else $error("result raised without a read or run");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_READ) |=> ##1 out_valid)
        else $error("row read did not produce a result");

endmodule

@@ hw/rtl/lgpe_dp.sv @@
module lgpe_dp
    import lgpe_pkg::*;
#(
    parameter int MAX_COLS = LGPE_MAX_COLS,
    parameter int MAX_ROWS = LGPE_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      cmd_byte,
    input  logic [ROW_IDX_W-1:0]  row_index,
    input  lgpe_cmd_t             cmd,
    output lgpe_stat_t            st,
    output logic                  result_kind,
    output logic [ROW_BITS_W-1:0] row_bits
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    // Configuration
    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [GEN_W-1:0]  gen_count_reg;
    logic [CCNT_W-1:0] used_cols;
    logic [RCNT_W-1:0] used_rows;
    logic [MAX_COLS-1:0] col_mask;

    // Grid storage
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [MAX_COLS-1:0] mem_q_reg;
    logic                q_ok_reg;

    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic                rd_ok;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic [MAX_COLS-1:0] wr_bmask;

    // Row pass engine
    logic                issue_act_reg;
    logic [RCNT_W-1:0]   issue_cnt_reg;
    logic                pass_life_reg;
    logic                stg_vld_reg;
    logic [RCNT_W-1:0]   stg_idx_reg;
    logic [RCNT_W-1:0]   wr_idx;
    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] dn_row;
    logic [MAX_COLS-1:0] new_row;
    logic                stg_write;
    logic                pass_start;

    // Cursor and pen
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;
    logic             pen_reg;
    logic [COL_W-1:0] col_nx;
    logic [ROW_W-1:0] row_nx;
    logic             pen_nx;
    logic             pen_hit;

    logic                  result_kind_reg;
    logic [ROW_BITS_W-1:0] row_bits_reg;

    // One B3/S23 step on a row, neighbor counts kept as bit-sliced counters
    function automatic logic [MAX_COLS-1:0] life_row(
        input logic [MAX_COLS-1:0] up,
        input logic [MAX_COLS-1:0] mid,
        input logic [MAX_COLS-1:0] dn,
        input logic [MAX_COLS-1:0] msk
    );
        logic [MAX_COLS-1:0] nb [8];
        logic [MAX_COLS-1:0] s0;
        logic [MAX_COLS-1:0] s1;
        logic [MAX_COLS-1:0] s2;
        logic [MAX_COLS-1:0] s3;
        logic [MAX_COLS-1:0] c0;
        logic [MAX_COLS-1:0] c1;
        logic [MAX_COLS-1:0] c2;
        logic [MAX_COLS-1:0] is2;
        logic [MAX_COLS-1:0] is3;
        nb[0] = up;
        nb[1] = (up << 1) & msk;
        nb[2] = up >> 1;
        nb[3] = dn;
        nb[4] = (dn << 1) & msk;
        nb[5] = dn >> 1;
        nb[6] = (mid << 1) & msk;
        nb[7] = mid >> 1;
        s0 = '0;
        s1 = '0;
        s2 = '0;
        s3 = '0;
        for (int k = 0; k < 8; k++)
        begin
            c0 = s0 & nb[k];
            s0 = s0 ^ nb[k];
            c1 = s1 & c0;
            s1 = s1 ^ c0;
            c2 = s2 & c1;
            s2 = s2 ^ c1;
            s3 = s3 | c2;
        end
        is2 = ~s3 & ~s2 & s1 & ~s0;
        is3 = ~s3 & ~s2 & s1 & s0;
        return (is3 | (mid & is2)) & msk;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= WIDTH_RST;
            grid_height_reg <= HEIGHT_RST;
            gen_count_reg   <= GENS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                CFG_GENS:   gen_count_reg   <= cfg_data[GEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            used_cols = CCNT_W'(1);
        else if (32'(grid_width_reg) > MAX_COLS)
            used_cols = CCNT_W'(MAX_COLS);
        else
            used_cols = CCNT_W'(grid_width_reg);

        if (grid_height_reg == '0)
            used_rows = RCNT_W'(1);
        else if (32'(grid_height_reg) > MAX_ROWS)
            used_rows = RCNT_W'(MAX_ROWS);
        else
            used_rows = RCNT_W'(grid_height_reg);

        for (int j = 0; j < MAX_COLS; j++)
            col_mask[j] = (j < int'(used_cols));
    end

    // Cursor moves and pen
    always_comb
    begin
        col_nx = cur_col_reg;
        row_nx = cur_row_reg;
        pen_nx = pen_reg;
        unique case (cmd_byte)
            CH_UP:
            begin
                if (cur_row_reg != '0)
                    row_nx = cur_row_reg - ROW_W'(1);
            end
            CH_DOWN:
            begin
                if ((RCNT_W'(cur_row_reg) + RCNT_W'(1)) < used_rows)
                    row_nx = cur_row_reg + ROW_W'(1);
            end
            CH_LEFT:
            begin
                if (cur_col_reg != '0)
                    col_nx = cur_col_reg - COL_W'(1);
            end
            CH_RIGHT:
            begin
                if ((CCNT_W'(cur_col_reg) + CCNT_W'(1)) < used_cols)
                    col_nx = cur_col_reg + COL_W'(1);
            end
            CH_PEN:
            begin
                pen_nx = !pen_reg;
            end
            default:
            begin
            end
        endcase
        pen_hit = pen_nx && (RCNT_W'(row_nx) < used_rows) && (CCNT_W'(col_nx) < used_cols);
    end

    // Shared read port: row reads win, otherwise the pass engine streams rows
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        rd_ok   = 1'b0;
        if (cmd.rd_start)
        begin
            rd_en   = 1'b1;
            rd_addr = ROW_W'(32'(row_index));
            rd_ok   = (32'(row_index) < 32'(used_rows)) && row_vld_reg[rd_addr];
        end
        else if (issue_act_reg && (issue_cnt_reg < used_rows))
        begin
            rd_en   = 1'b1;
            rd_addr = issue_cnt_reg[ROW_W-1:0];
            rd_ok   = row_vld_reg[rd_addr];
        end
    end

    assign dn_row    = q_ok_reg ? (mem_q_reg & col_mask) : '0;
    assign new_row   = pass_life_reg ? life_row(up_reg, cur_reg, dn_row, col_mask)
                                     : (cur_reg & col_mask);
    assign stg_write = stg_vld_reg && (stg_idx_reg != '0);
    assign wr_idx    = stg_idx_reg - RCNT_W'(1);
    assign pass_start = cmd.run_start || cmd.life_start;

    // Write port: pass results, or the pen bit under the cursor
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        wr_bmask = '0;
        if (stg_write)
        begin
            wr_en    = 1'b1;
            wr_addr  = wr_idx[ROW_W-1:0];
            wr_data  = new_row;
            wr_bmask = '1;
        end
        else if (cmd.cmd_apply && pen_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = row_nx;
            wr_data = MAX_COLS'(1) << col_nx;
            // a row never written reads as dead, so fill it whole
            wr_bmask = row_vld_reg[row_nx] ? (MAX_COLS'(1) << col_nx) : '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < MAX_COLS; i++)
            begin
                if (wr_bmask[i])
                    grid_mem[wr_addr][i] <= wr_data[i];
            end
        end
        if (rd_en)
            mem_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            q_ok_reg    <= 1'b0;
        end
        else
        begin
            q_ok_reg <= rd_en && rd_ok;
            if (cmd.run_start)
            begin
                // drop rows beyond the grid in use
                for (int r = 0; r < MAX_ROWS; r++)
                begin
                    if (r >= int'(used_rows))
                        row_vld_reg[r] <= 1'b0;
                end
            end
            if (wr_en)
                row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_act_reg <= 1'b0;
            issue_cnt_reg <= '0;
            pass_life_reg <= 1'b0;
            stg_vld_reg   <= 1'b0;
            stg_idx_reg   <= '0;
            up_reg        <= '0;
            cur_reg       <= '0;
        end
        else if (pass_start)
        begin
            issue_act_reg <= 1'b1;
            issue_cnt_reg <= '0;
            pass_life_reg <= cmd.life_start;
            stg_vld_reg   <= 1'b0;
            up_reg        <= '0;
            cur_reg       <= '0;
        end
        else
        begin
            if (issue_act_reg)
            begin
                stg_vld_reg <= 1'b1;
                stg_idx_reg <= issue_cnt_reg;
                // one extra dead row flushes the last grid row
                if (issue_cnt_reg == used_rows)
                    issue_act_reg <= 1'b0;
                else
                    issue_cnt_reg <= issue_cnt_reg + RCNT_W'(1);
            end
            else
            begin
                stg_vld_reg <= 1'b0;
            end
            if (stg_vld_reg)
            begin
                up_reg  <= cur_reg;
                cur_reg <= dn_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            pen_reg     <= 1'b0;
        end
        else if (cmd.cmd_apply)
        begin
            cur_col_reg <= col_nx;
            cur_row_reg <= row_nx;
            pen_reg     <= pen_nx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            result_kind_reg <= RES_ROW;
            row_bits_reg    <= ROW_BITS_W'(dn_row);
        end
        else if (cmd.load_done)
        begin
            result_kind_reg <= RES_DONE;
            row_bits_reg    <= '0;
        end
    end

    assign st.pass_done = stg_vld_reg && (stg_idx_reg == used_rows);
    assign st.gen_count = gen_count_reg;
    assign result_kind  = result_kind_reg;
    assign row_bits     = row_bits_reg;

endmodule
